[design/dnsqr_pkg.sv]
// dnsqr_pkg: shared types, constants and the answer-record byte table
// for the DNS query responder. No dependencies.
`default_nettype none

package dnsqr_pkg;

  // Packet limits
  localparam int MAX_PACKET_DEF  = 1024;
  localparam int HDR_BYTES       = 12;
  localparam int ANSWER_BYTES    = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Header byte positions that get rewritten
  localparam int HDR_FLAGS_HI   = 2;
  localparam int HDR_FLAGS_LO   = 3;
  localparam int HDR_ANCOUNT_HI = 6;
  localparam int HDR_ANCOUNT_LO = 7;

  localparam logic [7:0] QR_BIT      = 8'b1000_0000;
  localparam logic [7:0] NAME_PTR_HI = 8'b1100_0000;
  localparam logic [7:0] NAME_PTR_LO = 8'h0C;
  localparam logic [7:0] TYPE_A      = 8'h01;
  localparam logic [7:0] CLASS_IN    = 8'h01;
  localparam logic [7:0] RDLEN_A     = 8'h04;
  localparam logic [2:0] TAIL_BYTES  = 3'd4;

  // Config register reset values and indexes
  localparam logic [31:0] ADDR_RESET = 32'h0101_0101;
  localparam logic [31:0] TTL_RESET  = 32'd300;
  localparam logic        REG_ADDRESS = 1'b0;
  localparam logic        REG_TTL     = 1'b1;

  // What the back end does with one queued byte
  typedef enum logic [1:0] {
    CMD_ECHO    = 2'd0,  // plain echo
    CMD_BAD_END = 2'd1,  // echo, last byte of a malformed reply
    CMD_ANSWER  = 2'd2   // echo, then the 16-byte A record
  } cmd_kind_t;

  typedef struct packed {
    logic [7:0] data;
    cmd_kind_t  kind;
  } cmd_t;

  // Byte idx of the A record: pointer, type, class, TTL, rdlength, address
  function automatic logic [7:0] answer_byte(input logic [3:0]  idx,
                                             input logic [31:0] ttl,
                                             input logic [31:0] addr);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = NAME_PTR_HI;
      4'd1:    b = NAME_PTR_LO;
      4'd2:    b = 8'h00;
      4'd3:    b = TYPE_A;
      4'd4:    b = 8'h00;
      4'd5:    b = CLASS_IN;
      4'd6:    b = ttl[31:24];
      4'd7:    b = ttl[23:16];
      4'd8:    b = ttl[15:8];
      4'd9:    b = ttl[7:0];
      4'd10:   b = 8'h00;
      4'd11:   b = RDLEN_A;
      4'd12:   b = addr[31:24];
      4'd13:   b = addr[23:16];
      4'd14:   b = addr[15:8];
      default: b = addr[7:0];
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[design/dnsqr_if.sv]
// dnsqr_if: valid/ready stream interfaces for query bytes in and reply
// bytes out. No dependencies.
`default_nettype none

interface dnsqr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface dnsqr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       malformed;

  modport source (output valid, output out_byte, output out_last, output malformed,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input malformed,
                  output ready);
endinterface

`default_nettype wire

[design/dnsqr_front.sv]
// dnsqr_front: query parser. Tracks header, labels and QTYPE/QCLASS,
// rewrites header bytes and pushes one command per kept byte. Uses dnsqr_pkg.
`default_nettype none

module dnsqr_front #(
  parameter int MAX_PACKET = dnsqr_pkg::MAX_PACKET_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_byte,
  input  wire logic          in_last,
  output logic               push,
  output dnsqr_pkg::cmd_t    push_cmd,
  input  wire logic          push_ready
);
  import dnsqr_pkg::*;

  localparam int PW    = $clog2(MAX_PACKET);
  localparam int LIMIT = MAX_PACKET - ANSWER_BYTES;

  typedef enum logic [2:0] {
    PH_HEADER, PH_LABLEN, PH_LABEL, PH_TAIL, PH_DROP
  } phase_t;

  phase_t      phase, phase_next;
  logic [PW-1:0] pos, pos_next;
  logic [7:0]  label_left, label_left_next;
  logic [2:0]  tail_left, tail_left_next;
  logic        accept;
  logic        complete;
  logic [7:0]  ob;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  // Parse step for the byte on the input
  always_comb begin
    phase_next      = phase;
    pos_next        = pos;
    label_left_next = label_left;
    tail_left_next  = tail_left;
    complete        = 1'b0;
    ob              = in_byte;
    push            = 1'b0;
    push_cmd.data   = ob;
    push_cmd.kind   = CMD_ECHO;

    if (phase == PH_DROP) begin
      if (in_last) begin
        phase_next      = PH_HEADER;
        pos_next        = '0;
        label_left_next = '0;
        tail_left_next  = '0;
      end
    end else begin
      unique case (phase)
        PH_HEADER: begin
          if (pos == PW'(HDR_FLAGS_HI))        ob = in_byte | QR_BIT;
          else if (pos == PW'(HDR_FLAGS_LO))   ob = 8'h00;
          else if (pos == PW'(HDR_ANCOUNT_HI)) ob = 8'h00;
          else if (pos == PW'(HDR_ANCOUNT_LO)) ob = 8'h01;
          if (pos == PW'(HDR_BYTES - 1)) phase_next = PH_LABLEN;
        end
        PH_LABLEN: begin
          if (in_byte == 8'h00) begin
            tail_left_next = TAIL_BYTES;
            phase_next     = PH_TAIL;
          end else begin
            label_left_next = in_byte;
            phase_next      = PH_LABEL;
          end
        end
        PH_LABEL: begin
          if (label_left != 8'h00) label_left_next = label_left - 8'd1;
          if (label_left_next == 8'h00) phase_next = PH_LABLEN;
        end
        default: begin
          if (tail_left != 3'd0) tail_left_next = tail_left - 3'd1;
          complete = (tail_left_next == 3'd0);
        end
      endcase

      push          = accept;
      push_cmd.data = ob;
      if (pos >= PW'(LIMIT)) begin
        // reply would not fit: cut it here
        push_cmd.kind = CMD_BAD_END;
        phase_next    = PH_DROP;
      end else if (!complete) begin
        if (in_last) begin
          push_cmd.kind = CMD_BAD_END;
        end else begin
          push_cmd.kind = CMD_ECHO;
          pos_next      = pos + PW'(1);
        end
      end else begin
        push_cmd.kind = CMD_ANSWER;
        pos_next      = pos + PW'(1);
        phase_next    = PH_DROP;
      end

      if (in_last) begin
        phase_next      = PH_HEADER;
        pos_next        = '0;
        label_left_next = '0;
        tail_left_next  = '0;
      end
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      pos        <= '0;
      label_left <= '0;
      tail_left  <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      pos        <= pos_next;
      label_left <= label_left_next;
      tail_left  <= tail_left_next;
    end
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos <= PW'(LIMIT))
    else $error("byte position past the length limit");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && in_last |=> pos == '0 && phase == PH_HEADER)
    else $error("parser did not restart after the last byte");

  a_label_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_LABEL |-> label_left != 8'h00)
    else $error("label phase with no label bytes left");

endmodule

`default_nettype wire

[design/dnsqr_queue.sv]
// dnsqr_queue: small FIFO of commands between parser and reply generator.
// Uses dnsqr_pkg.
`default_nettype none

module dnsqr_queue #(
  parameter int DEPTH = dnsqr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire dnsqr_pkg::cmd_t  push_cmd,
  output logic                  push_ready,
  input  wire logic             pop,
  output dnsqr_pkg::cmd_t       pop_cmd,
  output logic                  pop_valid
);
  import dnsqr_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_cmd;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      if (do_push && !do_pop)      count <= count + CW'(1);
      else if (!do_push && do_pop) count <= count - CW'(1);
    end
  end

endmodule

`default_nettype wire

[design/dnsqr_back.sv]
// dnsqr_back: reply generator. Drains the command queue into the output
// register and appends the A record after the question. Uses dnsqr_pkg.
`default_nettype none

module dnsqr_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire dnsqr_pkg::cmd_t  pop_cmd,
  input  wire logic             pop_valid,
  output logic                  pop,
  input  wire logic [31:0]      answer_address,
  input  wire logic [31:0]      answer_ttl,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [7:0]            out_byte,
  output logic                  out_last,
  output logic                  malformed
);
  import dnsqr_pkg::*;

  logic       load;
  logic       ans_active;
  logic [3:0] ans_idx;

  assign load = !out_valid || out_ready;
  assign pop  = load && !ans_active && pop_valid;

  // Output register and answer sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      ans_active <= 1'b0;
      ans_idx    <= '0;
    end else if (load) begin
      if (ans_active) begin
        out_valid <= 1'b1;
        out_byte  <= answer_byte(ans_idx, answer_ttl, answer_address);
        out_last  <= (ans_idx == 4'd15);
        malformed <= 1'b0;
        ans_idx   <= ans_idx + 4'd1;
        if (ans_idx == 4'd15) ans_active <= 1'b0;
      end else if (pop_valid) begin
        out_valid <= 1'b1;
        out_byte  <= pop_cmd.data;
        out_last  <= (pop_cmd.kind == CMD_BAD_END);
        malformed <= (pop_cmd.kind == CMD_BAD_END);
        if (pop_cmd.kind == CMD_ANSWER) begin
          ans_active <= 1'b1;
          ans_idx    <= '0;
        end
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  a_answer_holds_output: assert property (@(posedge clk) disable iff (rst)
    ans_active |-> out_valid)
    else $error("answer in progress with empty output register");

  a_no_pop_in_answer: assert property (@(posedge clk) disable iff (rst)
    ans_active |-> !pop)
    else $error("queue popped during answer burst");

  a_good_end_after_answer: assert property (@(posedge clk) disable iff (rst)
    load && ans_active && ans_idx == 4'd15 |=> out_valid && out_last && !malformed)
    else $error("answer burst did not end with a good last byte");

endmodule

`default_nettype wire

[design/dns_query_responder.sv]
// dns_query_responder: top level. APB config registers, parser front end,
// command queue and reply back end. Uses dnsqr_pkg, dnsqr_if and submodules.
//
//  channel  | dir | payload                      | handshake
//  ---------+-----+------------------------------+-------------------------
//  query    | in  | in_byte, in_last             | valid/ready
//  reply    | out | out_byte, out_last, malformed| valid/ready
//  apb      | in  | paddr, pwdata -> prdata      | psel/penable, pready = 1
//
// One query byte per cycle is taken while the queue has room; a byte is
// classified and queued in the same cycle. While the reply side is ready,
// the back end emits one byte per cycle through its output register; a
// complete question adds the 16-byte A record to the output. The 4-entry
// queue fills during that burst, then the input stalls until the burst
// drains. Reset (rst, synchronous) empties the queue and restarts parsing at
// a packet header.
`default_nettype none

module dns_query_responder #(
  parameter int MAX_PACKET  = dnsqr_pkg::MAX_PACKET_DEF,
  parameter int QUEUE_DEPTH = dnsqr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  dnsqr_in_if.sink         query,
  dnsqr_out_if.source      reply,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import dnsqr_pkg::*;

  logic [31:0] answer_address;
  logic [31:0] answer_ttl;
  logic        push;
  logic        push_ready;
  cmd_t        push_cmd;
  logic        pop;
  logic        pop_valid;
  cmd_t        pop_cmd;

  // Configuration registers
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TTL) ? answer_ttl : answer_address;

  always_ff @(posedge clk) begin
    if (rst) begin
      answer_address <= ADDR_RESET;
      answer_ttl     <= TTL_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_ADDRESS) answer_address <= pwdata;
      else                         answer_ttl     <= pwdata;
    end
  end

  dnsqr_front #(.MAX_PACKET(MAX_PACKET)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (query.valid),
    .in_ready   (query.ready),
    .in_byte    (query.in_byte),
    .in_last    (query.in_last),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  dnsqr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_cmd    (pop_cmd),
    .pop_valid  (pop_valid)
  );

  dnsqr_back u_back (
    .clk            (clk),
    .rst            (rst),
    .pop_cmd        (pop_cmd),
    .pop_valid      (pop_valid),
    .pop            (pop),
    .answer_address (answer_address),
    .answer_ttl     (answer_ttl),
    .out_valid      (reply.valid),
    .out_ready      (reply.ready),
    .out_byte       (reply.out_byte),
    .out_last       (reply.out_last),
    .malformed      (reply.malformed)
  );

endmodule

`default_nettype wire

[sim/dnsqr_tb_pkg.sv]
`timescale 1ns / 100ps
// dnsqr_tb_pkg: reply predictor and scoreboard for the DNS query responder
// testbench. Depends on dnsqr_pkg for header positions and record constants.
package dnsqr_tb_pkg;
  import dnsqr_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  // Where the parser stands within the current query
  typedef enum logic [2:0] {
    Q_HEADER,
    Q_LABLEN,
    Q_LABEL,
    Q_TAIL,
    Q_DROP
  } qphase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       bad;
  } reply_beat_t;

  localparam int MAX_REPORTS = 40;

  class reply_scoreboard;
    int unsigned max_pkt;
    logic [31:0] addr_reg;
    logic [31:0] ttl_reg;

    // parser copy
    int unsigned byte_pos;
    qphase_t     phase;
    logic [7:0]  label_left;
    logic [2:0]  tail_left;

    reply_beat_t reply_q[$];

    int unsigned n_in, n_echoed, n_out, n_answers, n_bad, n_too_long, n_writes;
    int unsigned errors;

    function new(int unsigned max_packet);
      max_pkt  = max_packet;
      addr_reg = ADDR_RESET;
      ttl_reg  = TTL_RESET;
      restart();
    endfunction

    function void restart();
      byte_pos   = 0;
      phase      = Q_HEADER;
      label_left = '0;
      tail_left  = '0;
    endfunction

    function void set_reg(logic idx, logic [31:0] v);
      if (idx == REG_ADDRESS) addr_reg = v;
      else ttl_reg = v;
      n_writes++;
    endfunction

    function int unsigned pending();
      return reply_q.size();
    endfunction

    function void flag_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s: expected %0h, got %0h", $time, what, exp_v, got_v);
    endfunction

    function void push(logic [7:0] d, logic l, logic b);
      reply_beat_t e;
      e.data = d;
      e.last = l;
      e.bad  = b;
      reply_q.push_back(e);
      if (b) n_bad++;
    endfunction

    // One accepted query byte: advance the parser and queue its reply bytes
    function void note_query_byte(logic [7:0] b, logic last);
      logic [7:0]  ob;
      bit          q_done;
      int unsigned p;
      n_in++;
      if (phase == Q_DROP) begin
        if (last) restart();
        return;
      end
      n_echoed++;
      ob = b;
      q_done = 0;
      p = byte_pos;

      case (phase)
        Q_HEADER: begin
          if (p == HDR_FLAGS_HI) ob = b | QR_BIT;
          else if (p == HDR_FLAGS_LO || p == HDR_ANCOUNT_HI) ob = 8'h00;
          else if (p == HDR_ANCOUNT_LO) ob = 8'h01;
          if (p + 1 >= HDR_BYTES) phase = Q_LABLEN;
        end
        Q_LABLEN: begin
          // any nonzero length counts as a label, even compression marks
          if (b == 8'h00) begin
            tail_left = TAIL_BYTES;
            phase = Q_TAIL;
          end else begin
            label_left = b;
            phase = Q_LABEL;
          end
        end
        Q_LABEL: begin
          if (label_left != 0) label_left--;
          if (label_left == 0) phase = Q_LABLEN;
        end
        default: begin
          if (tail_left != 0) tail_left--;
          if (tail_left == 0) q_done = 1;
        end
      endcase

      // reply would overflow the packet limit: end it here as malformed
      if (p >= max_pkt - ANSWER_BYTES) begin
        push(ob, 1'b1, 1'b1);
        n_too_long++;
        if (last) restart();
        else phase = Q_DROP;
        return;
      end

      if (!q_done) begin
        if (last) begin
          push(ob, 1'b1, 1'b1);
          restart();
        end else begin
          push(ob, 1'b0, 1'b0);
          byte_pos = p + 1;
        end
        return;
      end

      // question complete: echo, then the A record
      push(ob, 1'b0, 1'b0);
      push(NAME_PTR_HI, 1'b0, 1'b0);
      push(NAME_PTR_LO, 1'b0, 1'b0);
      push(8'h00, 1'b0, 1'b0);
      push(TYPE_A, 1'b0, 1'b0);
      push(8'h00, 1'b0, 1'b0);
      push(CLASS_IN, 1'b0, 1'b0);
      push(ttl_reg[31:24], 1'b0, 1'b0);
      push(ttl_reg[23:16], 1'b0, 1'b0);
      push(ttl_reg[15:8], 1'b0, 1'b0);
      push(ttl_reg[7:0], 1'b0, 1'b0);
      push(8'h00, 1'b0, 1'b0);
      push(RDLEN_A, 1'b0, 1'b0);
      push(addr_reg[31:24], 1'b0, 1'b0);
      push(addr_reg[23:16], 1'b0, 1'b0);
      push(addr_reg[15:8], 1'b0, 1'b0);
      push(addr_reg[7:0], 1'b1, 1'b0);
      n_answers++;
      if (last) restart();
      else begin
        byte_pos = p + 1;
        phase = Q_DROP;
      end
    endfunction

    // One accepted reply byte against the oldest expected one
    function void check_reply_byte(logic [7:0] d, logic l, logic b);
      reply_beat_t e;
      n_out++;
      if (reply_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: reply byte %0h (last %b, malformed %b) with nothing pending",
                   $time, d, l, b);
        return;
      end
      e = reply_q.pop_front();
      if (d !== e.data)
        flag_mismatch($sformatf("reply byte %0d out_byte", n_out), e.data, d);
      if (l !== e.last)
        flag_mismatch($sformatf("reply byte %0d out_last", n_out), e.last, l);
      if (b !== e.bad)
        flag_mismatch($sformatf("reply byte %0d malformed", n_out), e.bad, b);
    endfunction
  endclass

endpackage

[sim/tb_dns_query_responder.sv]
`timescale 1ns / 100ps
// tb_dns_query_responder: drives query packets and APB writes into the
// responder and checks every reply byte. Depends on dnsqr_pkg, dnsqr_if, dnsqr_tb_pkg.
module tb_dns_query_responder;
  import dnsqr_pkg::*;
  import dnsqr_tb_pkg::*;

  localparam int MAX_PKT         = MAX_PACKET_DEF;
  localparam int CLK_HALF        = 5;
  localparam int IDLE_LIMIT      = 4000;
  localparam int DRAIN_CYCLES    = 24;
  localparam int PHASE_ITEMS     = 75;
  localparam int N_PHASES        = 6;
  localparam int HOLD_OFF_AT     = 150;
  localparam int HOLD_OFF_CYCLES = 200;

  typedef enum {PKT_GOOD, PKT_CUT, PKT_NOISE} pkt_kind_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  dnsqr_in_if  qif ();
  dnsqr_out_if rif ();

  reply_scoreboard sb = new(MAX_PKT);
  int unsigned idle_cycles;
  bit          hold_done;

  dns_query_responder #(.MAX_PACKET(MAX_PKT)) DUT (
    .clk     (clk),
    .rst     (rst),
    .query   (qif),
    .reply   (rif),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Gap length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void add_random(ref byte_q_t pkt, input int unsigned n);
    repeat (n) pkt.push_back(8'($urandom));
  endfunction

  // Random query: mostly well formed, some cut short, some plain noise
  function automatic byte_q_t make_query(pkt_kind_t kind);
    byte_q_t     pkt;
    int unsigned n, len, r, keep;
    if (kind == PKT_NOISE) begin
      add_random(pkt, $urandom_range(1, 40));
      return pkt;
    end
    add_random(pkt, HDR_BYTES);
    n = $urandom_range(0, 4);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 80) len = $urandom_range(1, 12);
      else if (r < 92) len = $urandom_range(13, 63);
      else if (r < 97) len = $urandom_range(64, 191);
      else len = $urandom_range(192, 255);
      pkt.push_back(8'(len));
      add_random(pkt, len);
    end
    pkt.push_back(8'h00);
    add_random(pkt, TAIL_BYTES);
    // trailing bytes after the question get dropped
    if ($urandom_range(0, 1) == 1) add_random(pkt, $urandom_range(1, 4));
    if (kind == PKT_CUT) begin
      keep = $urandom_range(1, pkt.size() - 1);
      while (pkt.size() > keep) void'(pkt.pop_back());
    end
    return pkt;
  endfunction

  // Well-formed query of an exact length, labels of up to 200 bytes
  function automatic byte_q_t make_long_query(int unsigned total);
    byte_q_t     pkt;
    int unsigned rem, chunk;
    add_random(pkt, HDR_BYTES);
    rem = total - HDR_BYTES - 1 - TAIL_BYTES;
    while (rem != 0) begin
      if (rem <= 201) chunk = rem;
      else if (rem - 201 >= 2) chunk = 201;
      else chunk = rem - 2;
      pkt.push_back(8'(chunk - 1));
      add_random(pkt, chunk - 1);
      rem -= chunk;
    end
    pkt.push_back(8'h00);
    add_random(pkt, TAIL_BYTES);
    return pkt;
  endfunction

  // One query byte: optional gap, then hold until the transfer
  task automatic send_byte(logic [7:0] b, logic l, int unsigned gap);
    repeat (gap) begin
      @(negedge clk);
      qif.valid <= 1'b0;
    end
    @(negedge clk);
    qif.valid   <= 1'b1;
    qif.in_byte <= b;
    qif.in_last <= l;
    do @(posedge clk); while (!qif.ready);
  endtask

  task automatic send_packet(input byte_q_t pkt);
    bit bursty;
    bursty = ($urandom_range(0, 3) == 0);
    foreach (pkt[i])
      send_byte(pkt[i], i == pkt.size() - 1, bursty ? 0 : pick_gap());
  endtask

  // Stop offering and wait for the block to go quiet
  task automatic drain_replies();
    @(negedge clk);
    qif.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB: setup cycle, access cycle, transfer when pready is high
  task automatic apb_access(input logic wr, input logic [2:0] a, input logic [31:0] wd,
                            output logic [31:0] rd);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= a;
    pwdata  <= wd;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_reg(logic idx, logic [31:0] v);
    logic [31:0] rd;
    apb_access(1'b0, {idx, 2'b00}, 32'h0, rd);
    if (rd !== v) sb.flag_mismatch($sformatf("register %0d readback", idx), v, rd);
  endtask

  task automatic write_reg(logic idx, logic [31:0] v);
    logic [31:0] rd;
    apb_access(1'b1, {idx, 2'b00}, v, rd);
    sb.set_reg(idx, v);
    check_reg(idx, v);
  endtask

  // Monitor: note query transfers, check reply transfers, watch for a hang
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (qif.valid && qif.ready) sb.note_query_byte(qif.in_byte, qif.in_last);
      if (rif.valid && rif.ready) sb.check_reply_byte(rif.out_byte, rif.out_last, rif.malformed);
      if ((qif.valid && qif.ready) || (rif.valid && rif.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d reply bytes outstanding",
                 $time, IDLE_LIMIT, sb.pending());
        $display("tb_dns_query_responder: done, errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Reply side: random stalls, ready-only stretches, one long hold-off
  initial begin : reply_sink
    int unsigned stall_left, mode_left, hold_left;
    bit          always_ready;
    rif.ready    = 1'b0;
    stall_left   = 0;
    mode_left    = 0;
    hold_left    = 0;
    always_ready = 0;
    hold_done    = 0;
    forever begin
      @(negedge clk);
      if (!hold_done && sb.n_in >= HOLD_OFF_AT) begin
        hold_done = 1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (mode_left == 0) begin
        always_ready = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      if (hold_left != 0) begin
        hold_left--;
        rif.ready <= 1'b0;
      end else if (always_ready) begin
        rif.ready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        rif.ready <= 1'b0;
      end else begin
        stall_left = pick_gap();
        rif.ready <= 1'b1;
      end
    end
  end

  // Stimulus: reset, directed packets, then random phases over register settings
  initial begin : stimulus
    logic [31:0] addr_set [N_PHASES];
    logic [31:0] ttl_set [N_PHASES];
    byte_q_t     pkt;
    int unsigned start_cnt, r;
    pkt_kind_t   kind;
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    qif.valid   = 1'b0;
    qif.in_byte = '0;
    qif.in_last = 1'b0;
    addr_set = '{ADDR_RESET, 32'h0, 32'hFFFF_FFFF, $urandom, 32'h8000_0000, $urandom};
    ttl_set  = '{TTL_RESET, 32'h0, 32'hFFFF_FFFF, $urandom, 32'h7FFF_FFFF, $urandom};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    check_reg(REG_ADDRESS, ADDR_RESET);
    check_reg(REG_TTL, TTL_RESET);

    // root-name question with all-ones and all-zeros header bytes, no
    // in_last on its final byte, then two dropped bytes ending the packet
    pkt = '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00,
            8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF,
            8'hA5, 8'h5A};
    send_packet(pkt);
    // packet that ends on its first byte
    pkt = '{8'hFF};
    send_packet(pkt);

    for (int k = 0; k < N_PHASES; k++) begin
      if (k != 0) begin
        write_reg(REG_ADDRESS, addr_set[k]);
        write_reg(REG_TTL, ttl_set[k]);
      end
      start_cnt = sb.n_echoed;
      while (sb.n_echoed - start_cnt < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 75) kind = PKT_GOOD;
        else if (r < 92) kind = PKT_CUT;
        else kind = PKT_NOISE;
        send_packet(make_query(kind));
      end
      // length-limit packet: every byte echoed up to the limit, the question's
      // final byte lands just past it, then dropped bytes end the packet
      if (k == 3) begin
        pkt = make_long_query(MAX_PKT - ANSWER_BYTES + 1);
        add_random(pkt, 3);
        send_packet(pkt);
      end
      drain_replies();
    end

    $display("covered %0d query bytes (%0d echoed), %0d reply bytes over %0d register writes",
             sb.n_in, sb.n_echoed, sb.n_out, sb.n_writes);
    $display("  %0d answers, %0d malformed endings, %0d at the length limit",
             sb.n_answers, sb.n_bad, sb.n_too_long);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_dns_query_responder: done, clean");
    end else begin
      $display("tb_dns_query_responder: done, errors");
    end
    $finish;
  end

endmodule
